// ----- rtl/core/tkf_pkg.sv -----
// Package for the tilt Kalman filter: widths, reset values, register addresses,
// sequencer states, write targets and the saturation helper. No dependencies.
package tkf_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned OpW     = 35;
	localparam int unsigned ProdW   = 2 * OpW;
	localparam int unsigned SumW    = 72;
	localparam int unsigned NumW    = 56;
	localparam int unsigned AddrW   = 4;

	localparam logic [16:0] StepTimeRst  = 17'd1311;
	localparam logic [30:0] MeasNoiseRst = 31'd5033165;
	localparam logic [30:0] AngNoiseRst  = 31'd16777;
	localparam logic [30:0] BiasNoiseRst = 31'd50332;
	localparam logic signed [31:0] OneQ24 = 32'sd16777216;

	localparam logic [1:0] RegStepTime  = 2'd0;
	localparam logic [1:0] RegMeasNoise = 2'd1;
	localparam logic [1:0] RegAngNoise  = 2'd2;
	localparam logic [1:0] RegBiasNoise = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		DST_AA,
		DST_AB,
		DST_BA,
		DST_BB,
		DST_ANGLE,
		DST_BIAS
	} dst_t;

	function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
		if (v > 72'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -72'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

// ----- rtl/core/tkf_if.sv -----
// Word channels of the tilt Kalman filter: sample input and estimate output.
// Valid/ready handshake; no dependencies.
interface tkf_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] sample;
	modport source (output valid, kind, sample, input ready);
	modport sink (input valid, kind, sample, output ready);
endinterface

interface tkf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] angle_estimate;
	logic [31:0] unbiased_rate;
	logic [31:0] bias_estimate;
	modport source (output valid, angle_estimate, unbiased_rate, bias_estimate, input ready);
	modport sink (input valid, angle_estimate, unbiased_rate, bias_estimate, output ready);
endinterface

// ----- rtl/core/tilt_kalman_filter_top.sv -----
// Two-state tilt Kalman filter (angle, gyro bias) with one shared multiplier
// and a radix-2 divider. Depends on tkf_pkg and tkf_if.
//
// channel  dir  word
// in_ch    in   kind, sample
// out_ch   out  angle_estimate, unbiased_rate, bias_estimate
// apb      in   step_time, measure_noise, angle_process_noise, bias_process_noise
//
// Predict word: covariance and angle updates via the multiplier, then the result.
// Correct word: both gains by the divider, then the updates, then the result.
// One word at a time; in_ch.ready is low from accept until out_ch takes the result.
// Reset is asynchronous; the state returns to unit covariance and zero estimates.
module tilt_kalman_filter_top
	import tkf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	tkf_in_if.sink           in_ch,
	tkf_out_if.source        out_ch,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [16:0] step_time_q;
	logic [30:0] meas_noise_q;
	logic [30:0] ang_noise_q;
	logic [30:0] bias_noise_q;

	logic signed [31:0] angle_q, bias_q, rate_q;
	logic signed [31:0] aa_q, ab_q, ba_q, bb_q;
	logic signed [31:0] k0_q, k1_q, err_q;

	state_t state_q, state_d;
	logic [2:0] op_q;
	logic       corr_q;
	logic       div_sel_q;
	logic [5:0] cnt_q;
	logic [NumW-1:0] num_q;
	logic [32:0] rem_q;
	logic [31:0] e_q;
	logic        neg_q;
	logic signed [ProdW-1:0] prod_s1;

	logic in_acc, out_acc;
	logic last_op;
	logic div_last;

	logic signed [OpW-1:0] op_a, op_b;
	logic signed [31:0]    op_acc;
	logic                  op_sh24, op_sub;
	dst_t                  op_dst;

	logic signed [ProdW-1:0] rnd16, rnd24;
	logic signed [SumW-1:0]  rnd_x, sum_x;
	logic signed [31:0]      wb;

	logic signed [32:0] e_x;
	logic               e_bad;
	logic [33:0]        rem_sh;
	logic               qbit;
	logic [NumW-1:0]    num_nx;
	logic signed [SumW-1:0] quo_x;

	logic [31:0] ab_mag;
	logic [31:0] p_mag;

	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[3:2])
			RegStepTime:  prdata = {15'd0, step_time_q};
			RegMeasNoise: prdata = {1'b0, meas_noise_q};
			RegAngNoise:  prdata = {1'b0, ang_noise_q};
			RegBiasNoise: prdata = {1'b0, bias_noise_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q  <= StepTimeRst;
			meas_noise_q <= MeasNoiseRst;
			ang_noise_q  <= AngNoiseRst;
			bias_noise_q <= BiasNoiseRst;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				RegStepTime:  step_time_q  <= pwdata[16:0];
				RegMeasNoise: meas_noise_q <= pwdata[30:0];
				RegAngNoise:  ang_noise_q  <= pwdata[30:0];
				RegBiasNoise: bias_noise_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign last_op = corr_q ? (op_q == 3'd5) : (op_q == 3'd4);
	assign div_last = (cnt_q == 6'(NumW - 1));

	// operand select for the shared multiply-accumulate
	always_comb begin
		op_a    = '0;
		op_b    = '0;
		op_acc  = '0;
		op_sh24 = corr_q;
		op_sub  = corr_q;
		op_dst  = DST_AA;
		if (!corr_q) begin
			op_b = {18'd0, step_time_q};
			unique case (op_q)
				3'd0: begin
					op_a = $signed({4'd0, ang_noise_q}) - {{3{ab_q[31]}}, ab_q}
						- {{3{ba_q[31]}}, ba_q};
					op_acc = aa_q; op_dst = DST_AA;
				end
				3'd1: begin
					op_a = -{{3{bb_q[31]}}, bb_q}; op_acc = ab_q; op_dst = DST_AB;
				end
				3'd2: begin
					op_a = -{{3{bb_q[31]}}, bb_q}; op_acc = ba_q; op_dst = DST_BA;
				end
				3'd3: begin
					op_a = $signed({4'd0, bias_noise_q}); op_acc = bb_q; op_dst = DST_BB;
				end
				default: begin
					op_a = {{3{rate_q[31]}}, rate_q}; op_acc = angle_q; op_dst = DST_ANGLE;
				end
			endcase
		end else begin
			unique case (op_q)
				3'd0: begin
					op_a = {{3{k1_q[31]}}, k1_q}; op_b = {{3{aa_q[31]}}, aa_q};
					op_acc = ba_q; op_dst = DST_BA;
				end
				3'd1: begin
					op_a = {{3{k1_q[31]}}, k1_q}; op_b = {{3{ab_q[31]}}, ab_q};
					op_acc = bb_q; op_dst = DST_BB;
				end
				3'd2: begin
					op_a = {{3{k0_q[31]}}, k0_q}; op_b = {{3{aa_q[31]}}, aa_q};
					op_acc = aa_q; op_dst = DST_AA;
				end
				3'd3: begin
					op_a = {{3{k0_q[31]}}, k0_q}; op_b = {{3{ab_q[31]}}, ab_q};
					op_acc = ab_q; op_dst = DST_AB;
				end
				3'd4: begin
					op_a = {{3{k0_q[31]}}, k0_q}; op_b = {{3{err_q[31]}}, err_q};
					op_acc = angle_q; op_dst = DST_ANGLE; op_sub = 1'b0;
				end
				default: begin
					op_a = {{3{k1_q[31]}}, k1_q}; op_b = {{3{err_q[31]}}, err_q};
					op_acc = bias_q; op_dst = DST_BIAS; op_sub = 1'b0;
				end
			endcase
		end
	end

	assign rnd16 = (prod_s1 + 70'sd32768) >>> 16;
	assign rnd24 = (prod_s1 + 70'sd8388608) >>> 24;
	assign rnd_x = op_sh24 ? {{2{rnd24[ProdW-1]}}, rnd24} : {{2{rnd16[ProdW-1]}}, rnd16};
	assign sum_x = op_sub ? ({{40{op_acc[31]}}, op_acc} - rnd_x)
		: ({{40{op_acc[31]}}, op_acc} + rnd_x);
	assign wb = sat32(sum_x);

	assign e_x   = {aa_q[31], aa_q} + $signed({2'd0, meas_noise_q});
	assign e_bad = e_x[32] || (e_x == '0);

	assign rem_sh = {rem_q, num_q[NumW-1]};
	assign qbit   = (rem_sh >= {2'd0, e_q});
	assign num_nx = {num_q[NumW-2:0], qbit};
	assign quo_x  = neg_q ? -$signed({16'd0, num_nx}) : $signed({16'd0, num_nx});

	assign ab_mag = aa_q[31] ? 32'(-aa_q) : aa_q;
	assign p_mag  = ba_q[31] ? 32'(-ba_q) : ba_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!in_ch.kind)
						state_d = ST_MUL;
					else if (e_bad)
						state_d = ST_OUT;
					else
						state_d = ST_DIV;
				end
			end
			ST_DIV:  if (div_last && div_sel_q) state_d = ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  state_d = last_op ? ST_OUT : ST_MUL;
			ST_OUT:  if (out_acc) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready  = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_OUT);
		out_ch.angle_estimate = angle_q;
		out_ch.unbiased_rate  = rate_q;
		out_ch.bias_estimate  = bias_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= '0;
			corr_q    <= 1'b0;
			div_sel_q <= 1'b0;
			cnt_q     <= '0;
			angle_q   <= '0;
			bias_q    <= '0;
			rate_q    <= '0;
			aa_q      <= OneQ24;
			ab_q      <= '0;
			ba_q      <= '0;
			bb_q      <= OneQ24;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					op_q      <= '0;
					cnt_q     <= '0;
					div_sel_q <= 1'b0;
					if (in_acc) begin
						corr_q <= in_ch.kind;
						if (!in_ch.kind)
							rate_q <= sat32($signed({{40{in_ch.sample[31]}}, in_ch.sample})
								- {{40{bias_q[31]}}, bias_q});
					end
				end
				ST_DIV: begin
					cnt_q <= div_last ? '0 : cnt_q + 6'd1;
					if (div_last)
						div_sel_q <= 1'b1;
				end
				ST_ACC: begin
					op_q <= op_q + 3'd1;
					unique case (op_dst)
						DST_AA:    aa_q    <= wb;
						DST_AB:    ab_q    <= wb;
						DST_BA:    ba_q    <= wb;
						DST_BB:    bb_q    <= wb;
						DST_ANGLE: angle_q <= wb;
						DST_BIAS:  bias_q  <= wb;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// divider and multiplier datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			e_q   <= e_x[31:0];
			err_q <= sat32($signed({{40{in_ch.sample[31]}}, in_ch.sample})
				- {{40{angle_q[31]}}, angle_q});
			num_q <= {ab_mag, 24'd0};
			neg_q <= aa_q[31];
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (div_last) begin
				if (!div_sel_q) begin
					k0_q  <= sat32(quo_x);
					num_q <= {p_mag, 24'd0};
					neg_q <= ba_q[31];
					rem_q <= '0;
				end else begin
					k1_q <= sat32(quo_x);
				end
			end else begin
				num_q <= num_nx;
				rem_q <= qbit ? 33'(rem_sh - {2'd0, e_q}) : rem_sh[32:0];
			end
		end
		if (state_q == ST_MUL)
			prod_s1 <= op_a * op_b;
	end

	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("ready while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("ready right after accept");

	a_acc_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> $past(state_q) == ST_MUL)
		else $error("writeback without product");

	a_div_only_corr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> corr_q)
		else $error("divider run on predict");

endmodule
